/* hw/rtl/matrix2x2_arith_unit_defines.svh */
// Assertion macros shared by the matrix unit RTL.
`ifndef MATRIX2X2_ARITH_UNIT_DEFINES_SVH
`define MATRIX2X2_ARITH_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
`define M2X2_ASSERT_IMP(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("m2x2 assertion failed");
`define M2X2_ASSERT_NXT(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("m2x2 assertion failed");
`else
`define M2X2_ASSERT_IMP(label, clk, rst_n, pre, post)
`define M2X2_ASSERT_NXT(label, clk, rst_n, pre, post)
`endif

`endif

/* hw/rtl/m2x2_pkg.sv */
package m2x2_pkg;

    typedef enum logic [2:0] {
        ACT_ADD    = 3'd0,
        ACT_SUB    = 3'd1,
        ACT_SCALE  = 3'd2,
        ACT_DIV    = 3'd3,
        ACT_MATMUL = 3'd4,
        ACT_MATVEC = 3'd5,
        ACT_EQUAL  = 3'd6
    } t_action;

    typedef logic signed [31:0] t_elem;

    localparam t_elem SAT_MAX = 32'sh7fff_ffff;
    localparam t_elem SAT_MIN = 32'sh8000_0000;

    // Remainder width of the divider; holds a magnitude shifted by up to 32 bits.
    localparam int REM_W = 64;

    typedef struct packed {
        logic [2:0] action;
        t_elem      a_r0c0;
        t_elem      a_r0c1;
        t_elem      a_r1c0;
        t_elem      a_r1c1;
        t_elem      b_r0c0;
        t_elem      b_r0c1;
        t_elem      b_r1c0;
        t_elem      b_r1c1;
        t_elem      scalar;
        t_elem      vec_x;
        t_elem      vec_y;
    } t_in_word;

    typedef struct packed {
        t_elem r_r0c0;
        t_elem r_r0c1;
        t_elem r_r1c0;
        t_elem r_r1c1;
        logic  is_equal;
        logic  error_flag;
    } t_out_word;

    // Word handed from the arithmetic front end to the divider pipeline.
    typedef struct packed {
        t_elem [3:0]             res;
        logic  [3:0][REM_W-1:0]  rem;
        logic  [31:0]            dsr;
        logic  [3:0]             lane_neg;
        logic  [3:0]             lane_ovf;
        logic                    is_div;
        logic                    eq;
        logic                    err;
    } t_mid;

    typedef struct packed {
        t_elem val;
        logic  err;
    } t_sat;

    function automatic t_sat sat65(input logic signed [64:0] v);
        t_sat s;
        s.val = v[31:0];
        s.err = 1'b0;
        if (v > 65'(SAT_MAX)) begin
            s.val = SAT_MAX;
            s.err = 1'b1;
        end else if (v < 65'(SAT_MIN)) begin
            s.val = SAT_MIN;
            s.err = 1'b1;
        end
        return s;
    endfunction

endpackage

/* hw/rtl/m2x2_chan_if.sv */
interface m2x2_in_if;
    logic                 valid;
    logic                 ready;
    m2x2_pkg::t_in_word   payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

interface m2x2_out_if;
    logic                 valid;
    logic                 ready;
    m2x2_pkg::t_out_word  payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

/* hw/rtl/m2x2_front.sv */
`include "matrix2x2_arith_unit_defines.svh"

// Four-stage front end: capture, multiply, sum and round, saturate and select.
module m2x2_front #(
    parameter int FRAC_BITS = 16
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    m2x2_in_if.sink         i_in,
    input  logic            i_mid_ready,
    output logic            o_mid_valid,
    output m2x2_pkg::t_mid  o_mid
);

    localparam int NS = 4;
    localparam logic signed [64:0] RND = $signed(65'd1 << (FRAC_BITS - 1));

    logic                en;
    logic [NS-1:0]       r_v;

    // Stage 1
    m2x2_pkg::t_in_word  r_w;

    // Stage 2
    m2x2_pkg::t_elem     ea [4];
    m2x2_pkg::t_elem     eb [4];
    m2x2_pkg::t_elem     opa [8];
    m2x2_pkg::t_elem     opb [8];
    logic signed [63:0]  r_p [8];
    logic signed [32:0]  r_as [4];
    logic [31:0]         r_mag_a [4];
    logic [3:0]          r_neg_a;
    logic [3:0]          r_zero_a;
    logic [31:0]         r_mag_s;
    logic                r_neg_s;
    logic                r_zero_s;
    logic                r_eq;
    logic [2:0]          r_act2;

    // Stage 3
    logic signed [64:0]  r_dot [4];
    logic signed [32:0]  r_as3 [4];
    logic [63:0]         r_dvd [4];
    logic [3:0]          r_ovf;
    logic [3:0]          r_neg_a3;
    logic [3:0]          r_zero_a3;
    logic [31:0]         r_mag_s3;
    logic                r_neg_s3;
    logic                r_zero_s3;
    logic                r_eq3;
    logic [2:0]          r_act3;

    // Stage 4
    m2x2_pkg::t_mid      n_mid;
    m2x2_pkg::t_mid      r_mid;

    assign en          = i_mid_ready;
    assign i_in.ready  = en;
    assign o_mid_valid = r_v[NS-1];
    assign o_mid       = r_mid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (en) begin
            r_v <= {r_v[NS-2:0], i_in.valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_w <= i_in.payload;
        end
    end

    always_comb begin
        ea[0] = r_w.a_r0c0;
        ea[1] = r_w.a_r0c1;
        ea[2] = r_w.a_r1c0;
        ea[3] = r_w.a_r1c1;
        eb[0] = r_w.b_r0c0;
        eb[1] = r_w.b_r0c1;
        eb[2] = r_w.b_r1c0;
        eb[3] = r_w.b_r1c1;
        for (int j = 0; j < 8; j++) begin
            opa[j] = '0;
            opb[j] = '0;
        end
        unique case (m2x2_pkg::t_action'(r_w.action))
            m2x2_pkg::ACT_SCALE: begin
                for (int i = 0; i < 4; i++) begin
                    opa[2*i] = ea[i];
                    opb[2*i] = r_w.scalar;
                end
            end
            m2x2_pkg::ACT_MATMUL: begin
                opa[0] = ea[0]; opb[0] = eb[0]; opa[1] = ea[1]; opb[1] = eb[2];
                opa[2] = ea[0]; opb[2] = eb[1]; opa[3] = ea[1]; opb[3] = eb[3];
                opa[4] = ea[2]; opb[4] = eb[0]; opa[5] = ea[3]; opb[5] = eb[2];
                opa[6] = ea[2]; opb[6] = eb[1]; opa[7] = ea[3]; opb[7] = eb[3];
            end
            m2x2_pkg::ACT_MATVEC: begin
                opa[0] = ea[0]; opb[0] = r_w.vec_x; opa[1] = ea[1]; opb[1] = r_w.vec_y;
                opa[2] = ea[2]; opb[2] = r_w.vec_x; opa[3] = ea[3]; opb[3] = r_w.vec_y;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int j = 0; j < 8; j++) begin
                r_p[j] <= opa[j] * opb[j];
            end
            for (int i = 0; i < 4; i++) begin
                if (m2x2_pkg::t_action'(r_w.action) == m2x2_pkg::ACT_SUB) begin
                    r_as[i] <= 33'(ea[i]) - 33'(eb[i]);
                end else begin
                    r_as[i] <= 33'(ea[i]) + 33'(eb[i]);
                end
                r_mag_a[i]  <= ea[i][31] ? 32'(-ea[i]) : 32'(ea[i]);
                r_neg_a[i]  <= ea[i][31];
                r_zero_a[i] <= (ea[i] == '0);
            end
            r_mag_s  <= r_w.scalar[31] ? 32'(-r_w.scalar) : 32'(r_w.scalar);
            r_neg_s  <= r_w.scalar[31];
            r_zero_s <= (r_w.scalar == '0);
            r_eq     <= (ea[0] == eb[0]) && (ea[1] == eb[1]) &&
                        (ea[2] == eb[2]) && (ea[3] == eb[3]);
            r_act2   <= r_w.action;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int i = 0; i < 4; i++) begin
                r_dot[i] <= (65'(r_p[2*i]) + 65'(r_p[2*i+1]) + RND) >>> FRAC_BITS;
                r_as3[i] <= r_as[i];
                r_dvd[i] <= 64'(r_mag_a[i]) << FRAC_BITS;
                // A quotient of 2^32 or more cannot come out of the 32 divider steps.
                r_ovf[i] <= (64'(r_mag_a[i]) << FRAC_BITS) >= {r_mag_s, 32'd0};
            end
            r_neg_a3  <= r_neg_a;
            r_zero_a3 <= r_zero_a;
            r_mag_s3  <= r_mag_s;
            r_neg_s3  <= r_neg_s;
            r_zero_s3 <= r_zero_s;
            r_eq3     <= r_eq;
            r_act3    <= r_act2;
        end
    end

    always_comb begin
        m2x2_pkg::t_sat s;
        n_mid = '0;
        s     = '0;
        unique case (m2x2_pkg::t_action'(r_act3)) inside
            m2x2_pkg::ACT_ADD, m2x2_pkg::ACT_SUB: begin
                for (int i = 0; i < 4; i++) begin
                    s = m2x2_pkg::sat65(65'(r_as3[i]));
                    n_mid.res[i] = s.val;
                    n_mid.err    = n_mid.err | s.err;
                end
            end
            m2x2_pkg::ACT_SCALE, m2x2_pkg::ACT_MATMUL: begin
                for (int i = 0; i < 4; i++) begin
                    s = m2x2_pkg::sat65(r_dot[i]);
                    n_mid.res[i] = s.val;
                    n_mid.err    = n_mid.err | s.err;
                end
            end
            m2x2_pkg::ACT_MATVEC: begin
                for (int i = 0; i < 2; i++) begin
                    s = m2x2_pkg::sat65(r_dot[i]);
                    n_mid.res[i] = s.val;
                    n_mid.err    = n_mid.err | s.err;
                end
            end
            m2x2_pkg::ACT_DIV: begin
                if (r_zero_s3) begin
                    // Division by zero saturates toward the sign of the dividend; a zero dividend gives zero.
                    n_mid.err = 1'b1;
                    for (int i = 0; i < 4; i++) begin
                        if (r_zero_a3[i]) begin
                            n_mid.res[i] = '0;
                        end else if (r_neg_a3[i]) begin
                            n_mid.res[i] = m2x2_pkg::SAT_MIN;
                        end else begin
                            n_mid.res[i] = m2x2_pkg::SAT_MAX;
                        end
                    end
                end else begin
                    n_mid.is_div = 1'b1;
                    n_mid.dsr    = r_mag_s3;
                    n_mid.lane_ovf = r_ovf;
                    for (int i = 0; i < 4; i++) begin
                        n_mid.rem[i]      = r_dvd[i];
                        n_mid.lane_neg[i] = r_neg_a3[i] ^ r_neg_s3;
                    end
                end
            end
            m2x2_pkg::ACT_EQUAL: begin
                n_mid.eq = r_eq3;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_mid <= n_mid;
        end
    end

    `M2X2_ASSERT_IMP(a_eq_no_err, i_clk, i_rst_n, r_v[NS-1] && r_mid.eq, !r_mid.err)
    `M2X2_ASSERT_IMP(a_div_nonzero, i_clk, i_rst_n, r_v[NS-1] && r_mid.is_div, r_mid.dsr != '0)
    `M2X2_ASSERT_NXT(a_stall_hold, i_clk, i_rst_n, r_v[NS-1] && !en, r_v[NS-1])

endmodule

/* hw/rtl/m2x2_div.sv */
`include "matrix2x2_arith_unit_defines.svh"

// 32-step restoring divider pipeline, one quotient bit per stage and lane,
// followed by sign fix-up, an output register and a skid register.
module m2x2_div (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_mid_valid,
    output logic            o_mid_ready,
    input  m2x2_pkg::t_mid  i_mid,
    m2x2_out_if.source      o_out
);

    localparam int NQ = 32;

    typedef struct packed {
        m2x2_pkg::t_mid     m;
        logic [3:0][31:0]   q;
    } t_dstage;

    logic                 en;
    logic [NQ-1:0]        r_v;
    t_dstage              src_st [NQ];
    t_dstage              n_st [NQ];
    t_dstage              r_st [NQ];
    m2x2_pkg::t_out_word  n_out;
    m2x2_pkg::t_out_word  r_out;
    m2x2_pkg::t_out_word  r_skid;
    logic                 r_ov;
    logic                 r_skid_v;

    // The pipeline moves whenever the skid register is free.
    assign en          = !r_skid_v;
    assign o_mid_ready = en;
    assign o_out.valid   = r_ov;
    assign o_out.payload = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (en) begin
            r_v <= {r_v[NQ-2:0], i_mid_valid};
        end
    end

    for (genvar k = 0; k < NQ; k++) begin : g_step
        localparam int B = NQ - 1 - k;

        if (k == 0) begin : g_first
            assign src_st[k].m = i_mid;
            assign src_st[k].q = '0;
        end else begin : g_next
            assign src_st[k] = r_st[k-1];
        end

        always_comb begin
            logic [m2x2_pkg::REM_W-1:0] d;
            n_st[k] = src_st[k];
            d       = m2x2_pkg::REM_W'(src_st[k].m.dsr) << B;
            for (int i = 0; i < 4; i++) begin
                if (src_st[k].m.rem[i] >= d) begin
                    n_st[k].m.rem[i] = src_st[k].m.rem[i] - d;
                    n_st[k].q[i][B]  = 1'b1;
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (en) begin
                r_st[k] <= n_st[k];
            end
        end
    end

    always_comb begin
        m2x2_pkg::t_elem   res [4];
        logic              err;
        logic [31:0]       q;
        err = r_st[NQ-1].m.err;
        q   = '0;
        for (int i = 0; i < 4; i++) begin
            res[i] = r_st[NQ-1].m.res[i];
        end
        if (r_st[NQ-1].m.is_div) begin
            for (int i = 0; i < 4; i++) begin
                q = r_st[NQ-1].q[i];
                if (!r_st[NQ-1].m.lane_neg[i]) begin
                    if (r_st[NQ-1].m.lane_ovf[i] || q[31]) begin
                        res[i] = m2x2_pkg::SAT_MAX;
                        err    = 1'b1;
                    end else begin
                        res[i] = q;
                    end
                end else begin
                    if (r_st[NQ-1].m.lane_ovf[i] || (q > 32'h8000_0000)) begin
                        res[i] = m2x2_pkg::SAT_MIN;
                        err    = 1'b1;
                    end else begin
                        res[i] = -q;
                    end
                end
            end
        end
        n_out.r_r0c0     = res[0];
        n_out.r_r0c1     = res[1];
        n_out.r_r1c0     = res[2];
        n_out.r_r1c1     = res[3];
        n_out.is_equal   = r_st[NQ-1].m.eq;
        n_out.error_flag = err;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov     <= 1'b0;
            r_skid_v <= 1'b0;
        end else begin
            if (o_out.ready && r_ov) begin
                if (r_skid_v) begin
                    r_out    <= r_skid;
                    r_skid_v <= 1'b0;
                end else if (!(en && r_v[NQ-1])) begin
                    r_ov <= 1'b0;
                end
            end
            if (en && r_v[NQ-1]) begin
                if (!r_ov || o_out.ready) begin
                    r_out <= n_out;
                    r_ov  <= 1'b1;
                end else begin
                    r_skid   <= n_out;
                    r_skid_v <= 1'b1;
                end
            end
        end
    end

    `M2X2_ASSERT_IMP(a_skid_needs_out, i_clk, i_rst_n, r_skid_v, r_ov)
    `M2X2_ASSERT_IMP(a_eq_clean, i_clk, i_rst_n, r_ov && r_out.is_equal,
        !r_out.error_flag && r_out.r_r0c0 == '0 && r_out.r_r0c1 == '0 &&
        r_out.r_r1c0 == '0 && r_out.r_r1c1 == '0)
    `M2X2_ASSERT_NXT(a_skid_drains, i_clk, i_rst_n, r_skid_v && o_out.ready, !r_skid_v)

endmodule

/* hw/rtl/matrix2x2_arith_unit.sv */
// Channel   Direction  Word         Contents
// i_in      in         t_in_word    action, matrices A and B, scalar, vector
// o_out     out        t_out_word   result matrix or vector, is_equal, error_flag
//
// Every action passes from acceptance to the output register through four
// front-end stages (capture, multiply, sum and round, saturate and select),
// 32 divider stages that each resolve one quotient bit, and the output stage.
// One word is accepted per cycle while the skid register is free; the 32-step divider sets the latency.
// Reset is synchronous and active low; it clears the valid bits and the skid.
// A stalled output holds the pipeline only once the skid register is full, so
// one further result is held in the skid register while a finished result waits.
module matrix2x2_arith_unit #(
    parameter int FRAC_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    m2x2_in_if.sink     i_in,
    m2x2_out_if.source  o_out
);

    // Hand-off between the multiply/round front end and the divider pipeline.
    logic            mid_valid;
    logic            mid_ready;
    m2x2_pkg::t_mid  mid;

    // Products, sums, saturation and divide-by-zero handling live here; the
    // divider pre-check flags quotients too large for 32 steps.
    m2x2_front #(
        .FRAC_BITS (FRAC_BITS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .i_mid_ready (mid_ready),
        .o_mid_valid (mid_valid),
        .o_mid       (mid)
    );

    // The divider carries non-divide results along unchanged so that every
    // word sees the same latency and results stay in order.
    m2x2_div u_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_mid_valid (mid_valid),
        .o_mid_ready (mid_ready),
        .i_mid       (mid),
        .o_out       (o_out)
    );

endmodule
